// ===== hw/rtl/etfp_pkg.sv =====
`default_nettype none

package etfp_pkg;

  localparam int INDEX_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int WORD_BITS  = FRAC_BITS + 4;
  localparam int STEP_BITS  = 30;
  localparam int ITER_BITS  = 16;
  localparam int GRAY_BITS  = 8;

  localparam int PROD_BITS  = INDEX_BITS + STEP_BITS;
  localparam int MUL_BITS   = 2 * WORD_BITS;
  localparam int EXT_BITS   = 2 * WORD_BITS - FRAC_BITS + 2;
  localparam int SAT_BITS   = (EXT_BITS > PROD_BITS + 2) ? EXT_BITS : PROD_BITS + 2;

  localparam int DIVD_BITS    = ITER_BITS + GRAY_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIVD_BITS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int REG_IDX_BITS = 2;
  localparam int ADDR_BITS    = REG_IDX_BITS + 2;
  localparam int DATA_BITS    = 32;

  localparam logic [REG_IDX_BITS-1:0] REG_MAX_ITER = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_X_STEP   = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_Y_STEP   = 2'd2;

  localparam logic [ITER_BITS-1:0] RST_MAX_ITER = 16'd1000;
  localparam logic [STEP_BITS-1:0] RST_X_STEP   = 30'd268435;
  localparam logic [STEP_BITS-1:0] RST_Y_STEP   = 30'd268435;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [SAT_BITS-1:0]  wide_t;
  typedef logic signed [MUL_BITS-1:0]  prod_t;

  localparam wide_t WIDE_MAX    = wide_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam wide_t WIDE_MIN    = ~WIDE_MAX;
  localparam wide_t FX_ONE      = wide_t'(1) << FRAC_BITS;
  localparam wide_t FX_FOUR     = wide_t'(4) << FRAC_BITS;
  localparam wide_t FX_TWO_HALF = wide_t'(5) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [ITER_BITS-1:0] max_iterations;
    logic [STEP_BITS-1:0] x_step;
    logic [STEP_BITS-1:0] y_step;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] column;
    logic [INDEX_BITS-1:0] row;
    word_t                 c_re;
    word_t                 c_im;
  } job_t;

  function automatic word_t sat_word(input wide_t v);
    word_t r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[WORD_BITS-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[WORD_BITS-1:0];
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/etfp_ifs.sv =====
`default_nettype none

interface etfp_pix_if;
  import etfp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] column;
  logic [INDEX_BITS-1:0] row;
  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface etfp_res_if;
  import etfp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] out_column;
  logic [INDEX_BITS-1:0] out_row;
  logic [ITER_BITS-1:0]  iterations;
  logic [GRAY_BITS-1:0]  gray;
  modport source (output valid, output out_column, output out_row, output iterations,
                  output gray, input ready);
  modport sink   (input valid, input out_column, input out_row, input iterations,
                  input gray, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/etfp_front.sv =====
`default_nettype none

module etfp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  etfp_pkg::cfg_t  cfg,
  etfp_pix_if.sink        in_pix,
  output etfp_pkg::job_t  job,
  output logic            job_valid,
  input  logic            job_ready
);
  import etfp_pkg::*;

  logic                  vld_r;
  logic [INDEX_BITS-1:0] col_r;
  logic [INDEX_BITS-1:0] row_r;
  word_t                 re_r;
  word_t                 im_r;
  logic [PROD_BITS-1:0]  re_prod;
  logic [PROD_BITS-1:0]  im_prod;
  wide_t                 re_wide;
  wide_t                 im_wide;
  logic                  take;

  assign in_pix.ready = !vld_r || job_ready;
  assign take         = in_pix.valid && in_pix.ready;

  assign re_prod = PROD_BITS'(in_pix.column) * PROD_BITS'(cfg.x_step);
  assign im_prod = PROD_BITS'(in_pix.row) * PROD_BITS'(cfg.y_step);
  assign re_wide = wide_t'(re_prod) - FX_TWO_HALF;
  assign im_wide = FX_ONE - wide_t'(im_prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (job_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      col_r <= in_pix.column;
      row_r <= in_pix.row;
      re_r  <= sat_word(re_wide);
      im_r  <= sat_word(im_wide);
    end
  end

  assign job_valid  = vld_r;
  assign job.column = col_r;
  assign job.row    = row_r;
  assign job.c_re   = re_r;
  assign job.c_im   = im_r;

endmodule

`default_nettype wire

// ===== hw/rtl/etfp_queue.sv =====
`default_nettype none

module etfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  etfp_pkg::job_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output etfp_pkg::job_t rd_data,
  output logic           rd_valid,
  input  logic           rd_ready
);
  import etfp_pkg::*;

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS:0]   cnt_r;
  logic                 push;
  logic                 pop;

  assign wr_ready = cnt_r != (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/etfp_core.sv =====
`default_nettype none

module etfp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  etfp_pkg::cfg_t cfg,
  input  etfp_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_ready,
  etfp_res_if.source     out_res
);
  import etfp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_UPD, S_DIV, S_OUT} state_t;

  state_t                  state_r;
  word_t                   x_r;
  word_t                   y_r;
  word_t                   cre_r;
  word_t                   cim_r;
  logic [INDEX_BITS-1:0]   col_r;
  logic [INDEX_BITS-1:0]   row_r;
  logic [ITER_BITS-1:0]    count_r;
  prod_t                   pxx_r;
  prod_t                   pyy_r;
  prod_t                   pxy_r;
  logic [ITER_BITS-1:0]    rem_r;
  logic [DIVD_BITS-1:0]    dvd_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;
  logic                    out_vld_r;
  logic [INDEX_BITS-1:0]   ocol_r;
  logic [INDEX_BITS-1:0]   orow_r;
  logic [ITER_BITS-1:0]    oiter_r;
  logic [GRAY_BITS-1:0]    ogray_r;

  wide_t                   xx;
  wide_t                   yy;
  wide_t                   xy;
  logic                    escape;
  word_t                   x_nxt;
  word_t                   y_nxt;
  logic [DIVD_BITS-1:0]    dvd_init;
  logic [ITER_BITS:0]      rem_sh;
  logic                    fits;
  logic [ITER_BITS:0]      rem_sub;
  logic [GRAY_BITS-1:0]    gray_val;

  assign xx     = wide_t'(prod_t'(pxx_r >>> FRAC_BITS));
  assign yy     = wide_t'(prod_t'(pyy_r >>> FRAC_BITS));
  assign xy     = wide_t'(prod_t'(pxy_r >>> (FRAC_BITS - 1)));
  assign escape = (xx + yy) >= FX_FOUR;
  assign x_nxt  = sat_word(xx - yy + wide_t'(cre_r));
  assign y_nxt  = sat_word(xy + wide_t'(cim_r));

  // count * (2^GRAY_BITS - 1)
  assign dvd_init = DIVD_BITS'({count_r, GRAY_BITS'(0)}) - DIVD_BITS'(count_r);

  // restoring divide, one quotient bit per cycle
  assign rem_sh   = {rem_r, dvd_r[DIVD_BITS-1]};
  assign fits     = rem_sh >= {1'b0, cfg.max_iterations};
  assign rem_sub  = rem_sh - {1'b0, cfg.max_iterations};
  assign gray_val = (cfg.max_iterations == '0) ? '0 : dvd_r[GRAY_BITS-1:0];

  assign job_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_res.ready && state_r != S_OUT) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            x_r     <= job.c_re;
            y_r     <= job.c_im;
            cre_r   <= job.c_re;
            cim_r   <= job.c_im;
            col_r   <= job.column;
            row_r   <= job.row;
            count_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (count_r >= cfg.max_iterations) begin
            dvd_r     <= dvd_init;
            rem_r     <= '0;
            div_cnt_r <= DIV_CNT_BITS'(DIVD_BITS);
            state_r   <= S_DIV;
          end else begin
            pxx_r   <= prod_t'(x_r) * prod_t'(x_r);
            pyy_r   <= prod_t'(y_r) * prod_t'(y_r);
            pxy_r   <= prod_t'(x_r) * prod_t'(y_r);
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (escape) begin
            dvd_r     <= dvd_init;
            rem_r     <= '0;
            div_cnt_r <= DIV_CNT_BITS'(DIVD_BITS);
            state_r   <= S_DIV;
          end else begin
            x_r     <= x_nxt;
            y_r     <= y_nxt;
            count_r <= count_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DIV: begin
          rem_r     <= fits ? rem_sub[ITER_BITS-1:0] : rem_sh[ITER_BITS-1:0];
          dvd_r     <= {dvd_r[DIVD_BITS-2:0], fits};
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == DIV_CNT_BITS'(1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld_r || out_res.ready) begin
            ocol_r    <= col_r;
            orow_r    <= row_r;
            oiter_r   <= count_r;
            ogray_r   <= gray_val;
            out_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid      = out_vld_r;
  assign out_res.out_column = ocol_r;
  assign out_res.out_row    = orow_r;
  assign out_res.iterations = oiter_r;
  assign out_res.gray       = ogray_r;

`ifndef ASSERT_OFF
  a_upd_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (count_r < cfg.max_iterations))
    else $error("step taken at iteration limit");
  a_div_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r != '0))
    else $error("divider count ran out in divide state");
  a_gray_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && cfg.max_iterations != '0) |-> (dvd_r[DIVD_BITS-1:GRAY_BITS] == '0))
    else $error("gray quotient exceeds range");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_vld_r || out_res.ready)) |=> (out_vld_r && state_r == S_IDLE))
    else $error("result not loaded into output register");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/escape_time_fractal_pixel.sv =====
`default_nettype none

// channel   dir  handshake        beat contents
// in_pix    in   valid/ready      column, row
// out_res   out  valid/ready      out_column, out_row, iterations, gray
// cfg       in   APB write/read   max_iterations @0x0, x_step @0x4, y_step @0x8
//
// One pixel at a time in the iteration engine: each iteration is a multiply step,
// then a compare/update step; the loop ends at the iteration limit or when the
// point escapes.
// Gray level comes from a 24-step restoring divider after the loop.
// Front stage and a 2-deep queue take new pixels while the engine is busy.
// Synchronous active-low reset clears control; registers reload defaults.
// Output register holds a result while the sink stalls; the engine keeps working.

module escape_time_fractal_pixel (
  input  logic                             clk,
  input  logic                             rst_n,
  etfp_pix_if.sink                         in_pix,
  etfp_res_if.source                       out_res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [etfp_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [etfp_pkg::DATA_BITS-1:0]   pwdata,
  output logic [etfp_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready
);
  import etfp_pkg::*;

  logic [ITER_BITS-1:0]    max_iter_r;
  logic [STEP_BITS-1:0]    x_step_r;
  logic [STEP_BITS-1:0]    y_step_r;
  logic [REG_IDX_BITS-1:0] reg_idx;
  cfg_t                    cfg;
  job_t                    fe_job;
  logic                    fe_valid;
  logic                    fe_ready;
  job_t                    q_job;
  logic                    q_valid;
  logic                    q_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= RST_MAX_ITER;
      x_step_r   <= RST_X_STEP;
      y_step_r   <= RST_Y_STEP;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_MAX_ITER: max_iter_r <= pwdata[ITER_BITS-1:0];
        REG_X_STEP:   x_step_r   <= pwdata[STEP_BITS-1:0];
        REG_Y_STEP:   y_step_r   <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ITER: prdata = DATA_BITS'(max_iter_r);
      REG_X_STEP:   prdata = DATA_BITS'(x_step_r);
      REG_Y_STEP:   prdata = DATA_BITS'(y_step_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.max_iterations = max_iter_r;
  assign cfg.x_step         = x_step_r;
  assign cfg.y_step         = y_step_r;

  etfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_pix    (in_pix),
    .job       (fe_job),
    .job_valid (fe_valid),
    .job_ready (fe_ready)
  );

  etfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (fe_job),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .rd_data  (q_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  etfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire
